// ===== src/tne_pkg.sv =====
// ----------------------------------------------------------------------------
// tne_pkg
// Shared widths, request/result types and a shift helper for the triangle
// normal, area and edge pipeline.
// ----------------------------------------------------------------------------
package tne_pkg;

    localparam int COORD_W   = 24;                  // Q12.12 corner coordinate
    localparam int NORM_FRAC = 14;                  // fraction bits of the normal
    localparam int TAG_W     = 16;

    localparam int EDGE_W  = COORD_W + 1;           // signed edge component
    localparam int PROD_W  = 2 * EDGE_W;            // signed product of edge components
    localparam int MAG_W   = 2 * COORD_W + 1;       // cross component magnitude
    localparam int CROSS_W = MAG_W + 1;             // signed cross component
    localparam int ESUM_W  = 2 * COORD_W + 2;       // edge squared length
    localparam int LO_W    = (MAG_W + 1) / 2;       // low half of a magnitude
    localparam int HI_W    = MAG_W - LO_W;          // high half of a magnitude
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W;
    localparam int LL_W    = 2 * LO_W;
    localparam int ASQ_W   = 2 * MAG_W;             // squared magnitude
    localparam int RAD_W   = ASQ_W + 2;             // square-root radicand
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;

    localparam int XN_W    = 30;                    // normalized cross magnitude
    localparam int XSQ_W   = 2 * XN_W;
    localparam int SSUM_W  = XSQ_W + 2;
    localparam int KN_W    = $clog2(MAG_W - XN_W + 1);
    localparam int M_W     = NORM_FRAC + 1;         // unsigned normal magnitude
    localparam int NORM_W  = NORM_FRAC + 2;
    localparam int NU_W    = SSUM_W + 2 * M_W + 6;  // signed working width of the divider
    localparam int NU_STAGES = M_W + 1;             // init stage plus one per quotient bit

    localparam int AREA_W  = 2 * COORD_W;
    localparam int SEDGE_W = COORD_W + 1;

    localparam int SQ_STAGES = ROOT_W;
    localparam int NDLY      = SQ_STAGES - NU_STAGES;

    typedef struct packed {
        logic [TAG_W-1:0]          tri_tag;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic                      last_in;
    } tne_req_t;

    typedef struct packed {
        logic [TAG_W-1:0]         tag_out;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic [AREA_W-1:0]        area;
        logic [SEDGE_W-1:0]       shortest_edge;
        logic                     degenerate;
        logic                     last_out;
    } tne_res_t;

    // Per-request side information that rides along the pipeline
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             last;
        logic [2:0]       neg;
        logic             degen;
    } tne_side_t;

    // Front end to back end hand-off
    typedef struct packed {
        logic                   valid;
        tne_side_t              side;
        logic [RAD_W-1:0]       area_rad;
        logic [RAD_W-1:0]       edge_rad;
        logic [2:0][XSQ_W-1:0]  xsq;
        logic [SSUM_W-1:0]      ssum;
    } tne_mid_t;

    // Right shift that brings every cross magnitude below 2^XN_W
    function automatic logic [KN_W-1:0] norm_shift(input logic [MAG_W-1:0] v);
        int len;
        len = 0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
                len = i + 1;
        end
        if (len > XN_W)
            return KN_W'(len - XN_W);
        else
            return '0;
    endfunction

endpackage

// ===== src/tne_sqrt.sv =====
// ----------------------------------------------------------------------------
// tne_sqrt
// Pipelined integer square root, one root bit per stage (restoring).
// ----------------------------------------------------------------------------
module tne_sqrt
    import tne_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  rad_reg  [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (k == 0)
        begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            rad_reg[k] <= rad_in;
            if (rem_sh >= trial)
            begin
                rem_reg[k]  <= rem_sh - trial;
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= rem_sh;
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

// ===== src/tne_unit.sv =====
// ----------------------------------------------------------------------------
// tne_unit
// Pipelined rounded quotient x*2^F/sqrt(S): one bit per stage, tested
// exactly as (2t-1)^2*S <= x^2*2^(2F+2) with running remainders.
// ----------------------------------------------------------------------------
module tne_unit
    import tne_pkg::*;
(
    input  logic              clk,
    input  logic [XSQ_W-1:0]  xsq,
    input  logic [SSUM_W-1:0] ssum,
    output logic [M_W-1:0]    mag
);

    // r: x^2*2^(2F+2) - (2m-1)^2*S, q: (2m-1)*S
    logic signed [NU_W-1:0] r_reg [NU_STAGES];
    logic signed [NU_W-1:0] q_reg [NU_STAGES];
    logic signed [NU_W-1:0] s_reg [NU_STAGES];
    logic [M_W-1:0]         m_reg [NU_STAGES];

    logic signed [NU_W-1:0] s_ext;
    logic signed [NU_W-1:0] x_ext;

    assign s_ext = $signed({{(NU_W-SSUM_W){1'b0}}, ssum});
    assign x_ext = $signed({{(NU_W-XSQ_W){1'b0}}, xsq});

    always_ff @(posedge clk)
    begin
        r_reg[0] <= (x_ext <<< (2*NORM_FRAC + 2)) - s_ext;
        q_reg[0] <= -s_ext;
        s_reg[0] <= s_ext;
        m_reg[0] <= '0;
    end

    for (genvar j = 1; j < NU_STAGES; j++)
    begin : g_bit
        localparam int B = M_W - j;
        logic signed [NU_W-1:0] t;

        assign t = r_reg[j-1] - (q_reg[j-1] <<< (B + 2)) - (s_reg[j-1] <<< (2*B + 2));

        always_ff @(posedge clk)
        begin
            s_reg[j] <= s_reg[j-1];
            if (!t[NU_W-1])
            begin
                r_reg[j] <= t;
                q_reg[j] <= q_reg[j-1] + (s_reg[j-1] <<< (B + 1));
                m_reg[j] <= m_reg[j-1] | (M_W'(1) << B);
            end
            else
            begin
                r_reg[j] <= r_reg[j-1];
                q_reg[j] <= q_reg[j-1];
                m_reg[j] <= m_reg[j-1];
            end
        end
    end

    assign mag = m_reg[NU_STAGES-1];

endmodule

// ===== src/tne_front.sv =====
// ----------------------------------------------------------------------------
// tne_front
// Edge vectors, cross product, squared lengths and normalization in
// seven register stages.
// ----------------------------------------------------------------------------
module tne_front
    import tne_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  tne_req_t req,
    output tne_mid_t mid
);

    logic [6:0] valid_reg;
    tne_side_t  side_reg [7];

    // stage 1
    logic signed [EDGE_W-1:0] e12_reg [3];
    logic signed [EDGE_W-1:0] e13_reg [3];
    logic signed [EDGE_W-1:0] e23_reg [3];
    // stage 2
    logic signed [PROD_W-1:0] pp_reg [6];
    logic [ESUM_W-1:0]        sq_reg [3][3];
    // stage 3
    logic signed [CROSS_W-1:0] c_reg  [3];
    logic [ESUM_W-1:0]         es_reg [3];
    // stage 4
    logic [MAG_W-1:0]  mag_reg [3];
    logic [KN_W-1:0]   kn_reg;
    logic [ESUM_W-1:0] emin4_reg;
    // stage 5
    logic [HH_W-1:0]   hh_reg [3];
    logic [HL_W-1:0]   hl_reg [3];
    logic [LL_W-1:0]   ll_reg [3];
    logic [XN_W-1:0]   x_reg  [3];
    logic [ESUM_W-1:0] emin5_reg;
    // stage 6
    logic [ASQ_W-1:0]  asq_reg  [3];
    logic [XSQ_W-1:0]  xsq6_reg [3];
    logic [ESUM_W-1:0] emin6_reg;
    // stage 7
    logic [RAD_W-1:0]  rad_reg;
    logic [SSUM_W-1:0] ssum_reg;
    logic [XSQ_W-1:0]  xsq7_reg [3];
    logic [ESUM_W-1:0] emin7_reg;

    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
    logic signed [COORD_W-1:0] pc [3];
    logic [MAG_W-1:0]          mag_next [3];
    logic [ESUM_W-1:0]         emin_next;

    assign pa = '{req.a_x, req.a_y, req.a_z};
    assign pb = '{req.b_x, req.b_y, req.b_z};
    assign pc = '{req.c_x, req.c_y, req.c_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_next[i] = c_reg[i][CROSS_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
        emin_next = (es_reg[0] < es_reg[1]) ? es_reg[0] : es_reg[1];
        if (es_reg[2] < emin_next)
            emin_next = es_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        // stage 1: edge vectors
        side_reg[0].tag   <= req.tri_tag;
        side_reg[0].last  <= req.last_in;
        side_reg[0].neg   <= '0;
        side_reg[0].degen <= 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            e12_reg[i] <= EDGE_W'(pb[i]) - EDGE_W'(pa[i]);
            e13_reg[i] <= EDGE_W'(pc[i]) - EDGE_W'(pa[i]);
            e23_reg[i] <= EDGE_W'(pc[i]) - EDGE_W'(pb[i]);
        end

        // stage 2: cross terms and edge squares
        side_reg[1] <= side_reg[0];
        pp_reg[0] <= e12_reg[1] * e13_reg[2];
        pp_reg[1] <= e12_reg[2] * e13_reg[1];
        pp_reg[2] <= e12_reg[2] * e13_reg[0];
        pp_reg[3] <= e12_reg[0] * e13_reg[2];
        pp_reg[4] <= e12_reg[0] * e13_reg[1];
        pp_reg[5] <= e12_reg[1] * e13_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[0][i] <= ESUM_W'(e12_reg[i] * e12_reg[i]);
            sq_reg[1][i] <= ESUM_W'(e13_reg[i] * e13_reg[i]);
            sq_reg[2][i] <= ESUM_W'(e23_reg[i] * e23_reg[i]);
        end

        // stage 3: cross components and squared lengths
        side_reg[2] <= side_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            c_reg[i]  <= CROSS_W'(pp_reg[2*i] - pp_reg[2*i+1]);
            es_reg[i] <= sq_reg[i][0] + sq_reg[i][1] + sq_reg[i][2];
        end

        // stage 4: magnitudes, signs, degenerate, shortest squared edge
        side_reg[3].tag   <= side_reg[2].tag;
        side_reg[3].last  <= side_reg[2].last;
        side_reg[3].neg   <= {c_reg[2][CROSS_W-1], c_reg[1][CROSS_W-1], c_reg[0][CROSS_W-1]};
        side_reg[3].degen <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
        for (int i = 0; i < 3; i++)
            mag_reg[i] <= mag_next[i];
        kn_reg    <= norm_shift(mag_next[0] | mag_next[1] | mag_next[2]);
        emin4_reg <= emin_next;

        // stage 5: split squares, normalize for the normal
        side_reg[4] <= side_reg[3];
        emin5_reg   <= emin4_reg;
        for (int i = 0; i < 3; i++)
        begin
            hh_reg[i] <= mag_reg[i][MAG_W-1:LO_W] * mag_reg[i][MAG_W-1:LO_W];
            hl_reg[i] <= mag_reg[i][MAG_W-1:LO_W] * mag_reg[i][LO_W-1:0];
            ll_reg[i] <= mag_reg[i][LO_W-1:0] * mag_reg[i][LO_W-1:0];
            x_reg[i]  <= XN_W'(mag_reg[i] >> kn_reg);
        end

        // stage 6: combine partial products, square normalized terms
        side_reg[5] <= side_reg[4];
        emin6_reg   <= emin5_reg;
        for (int i = 0; i < 3; i++)
        begin
            asq_reg[i]  <= (ASQ_W'(hh_reg[i]) << (2*LO_W))
                         + (ASQ_W'(hl_reg[i]) << (LO_W + 1))
                         + ASQ_W'(ll_reg[i]);
            xsq6_reg[i] <= x_reg[i] * x_reg[i];
        end

        // stage 7: sums of squares
        side_reg[6] <= side_reg[5];
        emin7_reg   <= emin6_reg;
        rad_reg     <= RAD_W'(asq_reg[0]) + RAD_W'(asq_reg[1]) + RAD_W'(asq_reg[2]);
        ssum_reg    <= SSUM_W'(xsq6_reg[0]) + SSUM_W'(xsq6_reg[1]) + SSUM_W'(xsq6_reg[2]);
        for (int i = 0; i < 3; i++)
            xsq7_reg[i] <= xsq6_reg[i];
    end

    always_comb
    begin
        mid.valid    = valid_reg[6];
        mid.side     = side_reg[6];
        mid.area_rad = rad_reg;
        mid.edge_rad = RAD_W'(emin7_reg);
        for (int i = 0; i < 3; i++)
            mid.xsq[i] = xsq7_reg[i];
        mid.ssum     = ssum_reg;
    end

endmodule

// ===== src/triangle_normal_area_edge.sv =====
// ----------------------------------------------------------------------------
// triangle_normal_area_edge
// Unit normal, area and shortest edge length of one triangle per clock.
// Throughput: one request per cycle; busy stays low, the receiver cannot
// stall and the pipeline always advances.
// The depth is set by the 50-stage square root of the area.
// Reset clears the valid bits only; no request is in flight after reset.
// ----------------------------------------------------------------------------
module triangle_normal_area_edge
    import tne_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tne_req_t req,
    output logic     done,
    output tne_res_t result
);

    tne_mid_t          mid;
    logic [ROOT_W-1:0] area_root;
    logic [ROOT_W-1:0] edge_root;
    logic [M_W-1:0]    nmag [3];

    // side information held until the square roots finish
    logic      valid_dly_reg [SQ_STAGES];
    tne_side_t side_dly_reg  [SQ_STAGES];
    // normal magnitudes held until the square roots finish
    logic [2:0][M_W-1:0] nmag_dly_reg [NDLY];

    logic     done_reg;
    tne_res_t res_reg;
    tne_res_t res_next;

    logic [ROOT_W-1:0] half_area;
    logic [M_W-1:0]    nm [3];
    logic signed [NORM_W-1:0] nsig [3];

    // The pipeline never stalls, so a request is taken whenever start is high
    assign busy = 1'b0;

    tne_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .req      (req),
        .mid      (mid)
    );

    tne_sqrt u_area_sqrt
    (
        .clk  (clk),
        .rad  (mid.area_rad),
        .root (area_root)
    );

    // floor(sqrt) is monotone: the root of the smallest squared edge is
    // the shortest edge length
    tne_sqrt u_edge_sqrt
    (
        .clk  (clk),
        .rad  (mid.edge_rad),
        .root (edge_root)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_norm
        tne_unit u_unit
        (
            .clk  (clk),
            .xsq  (mid.xsq[i]),
            .ssum (mid.ssum),
            .mag  (nmag[i])
        );
    end

    // Advance the valid bits; they carry control, so they reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
                valid_dly_reg[k] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            valid_dly_reg[0] <= mid.valid;
            for (int k = 1; k < SQ_STAGES; k++)
                valid_dly_reg[k] <= valid_dly_reg[k-1];
            done_reg <= valid_dly_reg[SQ_STAGES-1];
        end
    end

    // Advance the payload alongside
    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= mid.side;
        for (int k = 1; k < SQ_STAGES; k++)
            side_dly_reg[k] <= side_dly_reg[k-1];
        nmag_dly_reg[0] <= {nmag[2], nmag[1], nmag[0]};
        for (int k = 1; k < NDLY; k++)
            nmag_dly_reg[k] <= nmag_dly_reg[k-1];
        res_reg <= res_next;
    end

    // Assemble the result: sign the normal, drop it for a degenerate
    // triangle, halve and saturate the area
    always_comb
    begin
        half_area = area_root >> 1;
        for (int i = 0; i < 3; i++)
        begin
            nm[i] = nmag_dly_reg[NDLY-1][i];
            if (side_dly_reg[SQ_STAGES-1].degen)
                nsig[i] = '0;
            else if (side_dly_reg[SQ_STAGES-1].neg[i])
                nsig[i] = -$signed(NORM_W'(nm[i]));
            else
                nsig[i] = $signed(NORM_W'(nm[i]));
        end

        res_next.tag_out  = side_dly_reg[SQ_STAGES-1].tag;
        res_next.normal_x = nsig[0];
        res_next.normal_y = nsig[1];
        res_next.normal_z = nsig[2];
        if (half_area[ROOT_W-1:AREA_W] != '0)
            res_next.area = '1;
        else
            res_next.area = half_area[AREA_W-1:0];
        res_next.shortest_edge = edge_root[SEDGE_W-1:0];
        res_next.degenerate    = side_dly_reg[SQ_STAGES-1].degen;
        res_next.last_out      = side_dly_reg[SQ_STAGES-1].last;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== dv/tne_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tne_checker
// Watches the request and result channels of the triangle pipeline, works
// out normal, area and shortest edge of every accepted triangle and
// compares each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tne_checker
    import tne_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  tne_req_t req,
    input  logic     done,
    input  tne_res_t result,
    output int       errors,
    output int       outstanding
);

    tne_res_t pending_q[$];

    initial errors = 0;
    assign outstanding = pending_q.size();

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tt;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            tt = {64'd0, t};
            if (tt * tt <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] edge_length(longint dx, longint dy, longint dz);
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] az;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        return isqrt128(ax * ax + ay * ay + az * az);
    endfunction

    // Geometry of one triangle: unit normal, area and shortest edge
    function automatic tne_res_t tri_geometry(tne_req_t r);
        tne_res_t     o;
        longint       p[9];
        longint       e12[3];
        longint       e13[3];
        longint       e23[3];
        longint       cr[3];
        logic [127:0] mg[3];
        logic [127:0] asum;
        logic [63:0]  half;
        logic [63:0]  l12;
        logic [63:0]  l13;
        logic [63:0]  l23;
        logic [63:0]  sh;
        logic [63:0]  xs[3];
        logic [63:0]  s2;
        logic [127:0] rhs;
        logic [127:0] dd;
        logic [127:0] s2w;
        logic [15:0]  m;
        logic [15:0]  t;
        int           kn;
        logic         fits;
        p[0] = longint'(r.a_x); p[1] = longint'(r.a_y); p[2] = longint'(r.a_z);
        p[3] = longint'(r.b_x); p[4] = longint'(r.b_y); p[5] = longint'(r.b_z);
        p[6] = longint'(r.c_x); p[7] = longint'(r.c_y); p[8] = longint'(r.c_z);
        for (int i = 0; i < 3; i++)
        begin
            e12[i] = p[3 + i] - p[i];
            e13[i] = p[6 + i] - p[i];
            e23[i] = p[6 + i] - p[3 + i];
        end
        cr[0] = e12[1] * e13[2] - e12[2] * e13[1];
        cr[1] = e12[2] * e13[0] - e12[0] * e13[2];
        cr[2] = e12[0] * e13[1] - e12[1] * e13[0];
        asum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = (cr[i] < 0) ? -cr[i] : cr[i];
            asum += mg[i] * mg[i];
        end
        // magnitudes stay far below 2^62 here, so the area needs no prescale
        half = isqrt128(asum) >> 1;
        o = '0;
        o.tag_out = r.tri_tag;
        o.last_out = r.last_in;
        o.area = (half > {16'd0, {AREA_W{1'b1}}}) ? {AREA_W{1'b1}} : half[AREA_W-1:0];
        l12 = edge_length(e12[0], e12[1], e12[2]);
        l13 = edge_length(e13[0], e13[1], e13[2]);
        l23 = edge_length(e23[0], e23[1], e23[2]);
        sh = (l12 < l13) ? l12 : l13;
        if (l23 < sh)
            sh = l23;
        o.shortest_edge = sh[SEDGE_W-1:0];
        o.degenerate = (mg[0] == 0) && (mg[1] == 0) && (mg[2] == 0);
        if (!o.degenerate)
        begin
            // smallest shift that brings every magnitude below 2^30
            kn = 0;
            fits = 1'b0;
            while (!fits)
            begin
                fits = 1'b1;
                for (int i = 0; i < 3; i++)
                    if ((mg[i] >> kn) >= (128'd1 << 30))
                        fits = 1'b0;
                if (!fits)
                    kn++;
            end
            s2 = '0;
            for (int i = 0; i < 3; i++)
            begin
                xs[i] = 64'(mg[i] >> kn);
                s2 += xs[i] * xs[i];
            end
            s2w = {64'd0, s2};
            for (int i = 0; i < 3; i++)
            begin
                rhs = ({64'd0, xs[i]} * {64'd0, xs[i]}) << (2 * NORM_FRAC + 2);
                m = '0;
                // round to nearest: accept bit while (2t-1)^2 * S <= 4 x^2 2^2F
                for (int b = NORM_FRAC; b >= 0; b--)
                begin
                    t = m | (16'd1 << b);
                    dd = 2 * t - 1;
                    if (dd * dd * s2w <= rhs)
                        m = t;
                end
                if (cr[i] < 0)
                    m = -m;
                if (i == 0) o.normal_x = m;
                if (i == 1) o.normal_y = m;
                if (i == 2) o.normal_z = m;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        tne_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_q.size() == 0)
                    report_mismatch("unexpected result", result.tag_out, 0);
                else
                begin
                    want = pending_q.pop_front();
                    if (result.tag_out !== want.tag_out)
                        report_mismatch("tag_out", result.tag_out, want.tag_out);
                    if (result.normal_x !== want.normal_x)
                        report_mismatch("normal_x", result.normal_x, want.normal_x);
                    if (result.normal_y !== want.normal_y)
                        report_mismatch("normal_y", result.normal_y, want.normal_y);
                    if (result.normal_z !== want.normal_z)
                        report_mismatch("normal_z", result.normal_z, want.normal_z);
                    if (result.area !== want.area)
                        report_mismatch("area", result.area, want.area);
                    if (result.shortest_edge !== want.shortest_edge)
                        report_mismatch("shortest_edge", result.shortest_edge,
                                        want.shortest_edge);
                    if (result.degenerate !== want.degenerate)
                        report_mismatch("degenerate", result.degenerate, want.degenerate);
                    if (result.last_out !== want.last_out)
                        report_mismatch("last_out", result.last_out, want.last_out);
                end
            end
            if (start && !busy)
                pending_q.push_back(tri_geometry(req));
        end
    end

endmodule

// ===== dv/tb_triangle_normal_area_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_normal_area_edge
// Drives directed and random triangles into the normal/area/edge pipeline
// with random gaps; a checker beside the block predicts and compares every
// result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_triangle_normal_area_edge;
    import tne_pkg::*;

    localparam int RAND_TRIS  = 1030;
    localparam int DRAIN_WAIT = 70;     // a little over the pipeline latency
    localparam int STALL_MAX  = 2000;   // cycles without any handshake

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] ONE  = 24'sd4096;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    tne_req_t req;
    logic     done;
    tne_res_t result;
    int       errors;
    int       outstanding;
    int       idle_cycles;
    bit       burst;

    triangle_normal_area_edge dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    tne_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one request; called at a falling edge and returns at one.
    // Gaps come in random lengths except inside back-to-back stretches.
    task automatic send_tri(tne_req_t r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic tne_req_t make_tri(int tag, logic signed [COORD_W-1:0] ax,
        logic signed [COORD_W-1:0] ay, logic signed [COORD_W-1:0] az,
        logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by,
        logic signed [COORD_W-1:0] bz, logic signed [COORD_W-1:0] cx,
        logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] cz, logic last);
        tne_req_t r;
        r.tri_tag = TAG_W'(tag);
        r.a_x = ax; r.a_y = ay; r.a_z = az;
        r.b_x = bx; r.b_y = by; r.b_z = bz;
        r.c_x = cx; r.c_y = cy; r.c_z = cz;
        r.last_in = last;
        return r;
    endfunction

    // Random triangle drawn from a mix of shapes
    function automatic tne_req_t random_tri();
        tne_req_t r;
        int       base[3];
        int       d[3];
        int       kind;
        int       span;
        r = tne_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(2, 21);
        for (int i = 0; i < 3; i++)
        begin
            base[i] = $urandom_range(0, 2 * (1 << 21)) - (1 << 21);
            d[i]    = $urandom_range(0, 2 * span) - span;
        end
        if (kind <= 3)
        begin
            // small triangle around a point: corners a short way apart
            r.a_x = COORD_W'(base[0]); r.a_y = COORD_W'(base[1]);
            r.a_z = COORD_W'(base[2]);
            r.b_x = COORD_W'(base[0] + d[0]); r.b_y = COORD_W'(base[1] + d[1]);
            r.b_z = COORD_W'(base[2] + d[2]);
            r.c_x = COORD_W'(base[0] + $urandom_range(0, 2 * span) - span);
            r.c_y = COORD_W'(base[1] + $urandom_range(0, 2 * span) - span);
            r.c_z = COORD_W'(base[2] + $urandom_range(0, 2 * span) - span);
        end
        else if (kind == 4)
        begin
            // near-collinear corners: c on or close to the line through a and b
            r.a_x = COORD_W'(base[0]); r.a_y = COORD_W'(base[1]);
            r.a_z = COORD_W'(base[2]);
            r.b_x = COORD_W'(base[0] + d[0] / 4); r.b_y = COORD_W'(base[1] + d[1] / 4);
            r.b_z = COORD_W'(base[2] + d[2] / 4);
            r.c_x = COORD_W'(base[0] - d[0] / 2); r.c_y = COORD_W'(base[1] - d[1] / 2);
            r.c_z = COORD_W'(base[2] - d[2] / 2);
        end
        else if (kind == 5)
        begin
            // two corners coincide
            r.c_x = r.a_x; r.c_y = r.a_y; r.c_z = r.a_z;
        end
        else if (kind == 6)
        begin
            // flat in z: normal straight along the axis
            r.b_z = r.a_z; r.c_z = r.a_z;
        end
        else if (kind == 7)
        begin
            // one coordinate of each corner pinned to an extreme
            r.a_x = $urandom_range(0, 1) ? CMAX : CMIN;
            r.b_y = $urandom_range(0, 1) ? CMAX : CMIN;
            r.c_z = $urandom_range(0, 1) ? CMAX : CMIN;
        end
        return r;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        burst = 1'b0;
        idle_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zeros, extremes, axis normals, degenerate shapes
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_tri(make_tri(16'hffff, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1));
        send_tri(make_tri(2, 0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1'b0));
        send_tri(make_tri(3, 0, 0, 0, 0, 0, ONE, ONE, 0, 0, 1'b0));
        send_tri(make_tri(4, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0));
        send_tri(make_tri(5, ONE, ONE, ONE, ONE, ONE, ONE, -ONE, 0, ONE, 1'b0));
        send_tri(make_tri(6, 0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b0));
        send_tri(make_tri(7, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 1'b1));
        send_tri(make_tri(8, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 1'b0));
        send_tri(make_tri(9, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b0));
        send_tri(make_tri(10, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 1'b0));
        send_tri(make_tri(11, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0));
        send_tri(make_tri(12, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));
        send_tri(make_tri(13, 0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
        send_tri(make_tri(14, 0, 0, 0, 1, 1, 0, -1, 1, 0, 1'b0));
        send_tri(make_tri(15, 5, 7, -3, 5, 7, -3, 100, -200, 300, 1'b0));
        send_tri(make_tri(16, CMIN, 0, 0, CMAX, 0, 0, 0, 0, 0, 1'b0));
        send_tri(make_tri(17, 0, 0, 0, 3, 4, 0, 4, -3, 12, 1'b1));

        // random: alternate stretches of back-to-back and gapped traffic
        for (int n = 0; n < RAND_TRIS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            send_tri(random_tri());
        end
        start <= 1'b0;

        // drain, then let the pipeline settle
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/tne_pkg.sv
src/tne_sqrt.sv
src/tne_unit.sv
src/tne_front.sv
src/triangle_normal_area_edge.sv
dv/tne_checker.sv
dv/tb_triangle_normal_area_edge.sv
